>>> rtl/core/ssba_pkg.sv
// Shared types and constants for the stack slot bitmap allocator.
// No dependencies; imported by the top module, ssba_addsub and the bench.
package ssba_pkg;

    localparam int ADDR_W  = 48;
    localparam int PAGES_W = 17;
    localparam int SLOTO_W = 6;
    localparam int CFG_W   = ADDR_W;

    localparam logic [ADDR_W-1:0]  POOL_BASE_RESET = 48'h0200_0000_0000;
    localparam logic [PAGES_W-1:0] PAGES_RESET     = 17'd256;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef enum logic {
        CFG_POOL_BASE   = 1'b0,
        CFG_STACK_PAGES = 1'b1
    } t_cfg_idx;

    localparam logic MODE_ALLOC = 1'b0;

    // operands of the shared add/subtract unit
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } t_alu_req;

    typedef struct packed {
        logic [ADDR_W-1:0] sum;
        logic              carry;   // on subtract: 1 means a >= b
    } t_alu_rsp;

endpackage

>>> rtl/core/stack_slot_bitmap_allocator_top.sv
// Stack slot bitmap allocator: hands out equal-sized stack regions from a pool
// of MAX_SLOTS slots, one used bit per slot held in a small RAM.
// Depends on ssba_pkg, ssba_ram and ssba_addsub.
//
// After reset a clearing pass writes every slot free, one slot a cycle; input
// words are stalled meanwhile (config writes still land). Then one request is
// handled at a time. An allocate scans up from slot 0 and stops at the lowest
// free slot, or after the last slot when the pool is full. A free stops at the
// slot the address falls in, or after the last slot when the address lies past
// it; an address below the pool base is answered straight from S_PREP. A result
// that finds the previous one still waiting for the sink waits in S_DONE until
// the sink takes it. The next request is accepted in the cycle after a result
// is registered. Both loops run around the one shared 48-bit add/subtract unit:
// the allocate scan reads one bit a cycle from the RAM and steps the region
// base by the region size, and the free divides the offset by the region size
// through repeated subtraction, one slot a cycle. The result sits in an output
// register, so the next request is taken while a result waits for the sink.
module stack_slot_bitmap_allocator_top
    import ssba_pkg::*;
#(
    parameter int MAX_SLOTS  = 64,
    parameter int PAGE_BYTES = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [ADDR_W-1:0]  i_stack_address,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [ADDR_W-1:0]  o_region_base,
    output logic [SLOTO_W-1:0] o_slot_index,
    output logic [1:0]         o_status
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SIZE_W = PAGES_W + $clog2(PAGE_BYTES + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_SLOTS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_DIV,
        S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_acc, n_acc;     // running base (alloc) or offset (free)
    logic [ADDR_W-1:0]   r_size, n_size;
    logic                r_mode, n_mode;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [ADDR_W-1:0]   r_pool_base, n_pool_base;
    logic [PAGES_W-1:0]  r_stack_pages, n_stack_pages;

    logic [ADDR_W-1:0]   r_res_base, n_res_base;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    t_status             r_res_status, n_res_status;

    logic                r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]   r_out_base, n_out_base;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    t_status             r_out_status, n_out_status;

    logic                w_ram_we;
    logic [SLOT_W-1:0]   w_ram_waddr;
    logic [0:0]          w_ram_wdata;
    logic [SLOT_W-1:0]   w_ram_raddr;
    logic [0:0]          w_ram_rdata;

    t_alu_req            w_alu_req;
    t_alu_rsp            w_alu_rsp;
    logic [PAGES_W-1:0]  w_pages_eff;

    ssba_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    ssba_addsub u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    // zero pages behaves as one page
    assign w_pages_eff = (r_stack_pages == '0) ? PAGES_W'(1) : r_stack_pages;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_acc         = r_acc;
        n_size        = r_size;
        n_mode        = r_mode;
        n_addr        = r_addr;
        n_pool_base   = r_pool_base;
        n_stack_pages = r_stack_pages;
        n_res_base    = r_res_base;
        n_res_slot    = r_res_slot;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid;
        n_out_base    = r_out_base;
        n_out_slot    = r_out_slot;
        n_out_status  = r_out_status;

        w_ram_we      = 1'b0;
        w_ram_waddr   = r_cnt;
        w_ram_wdata   = 1'b0;
        w_ram_raddr   = r_cnt;
        w_alu_req.a   = r_acc;
        w_alu_req.b   = r_size;
        w_alu_req.sub = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POOL_BASE:   n_pool_base   = i_cfg_data[ADDR_W-1:0];
                CFG_STACK_PAGES: n_stack_pages = i_cfg_data[PAGES_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_wdata = 1'b0;
                if (r_cnt == LAST_SLOT) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_mode  = i_mode;
                    n_addr  = i_stack_address;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                // region size: one narrow multiply, registered before use
                n_size      = ADDR_W'(SIZE_W'(w_pages_eff) * SIZE_W'(PAGE_BYTES));
                n_cnt       = '0;
                w_ram_raddr = '0;
                if (r_mode == MODE_ALLOC) begin
                    n_acc   = r_pool_base;
                    n_state = S_SCAN;
                end else begin
                    w_alu_req.a   = r_addr;
                    w_alu_req.b   = r_pool_base;
                    w_alu_req.sub = 1'b1;
                    if (!w_alu_rsp.carry) begin
                        n_res_base   = '0;
                        n_res_slot   = '0;
                        n_res_status = ST_OUTSIDE;
                        n_state      = S_DONE;
                    end else begin
                        n_acc   = w_alu_rsp.sum;
                        n_state = S_DIV;
                    end
                end
            end
            S_SCAN: begin
                // read data belongs to slot r_cnt; fetch the next one
                w_ram_raddr = r_cnt + SLOT_W'(1);
                if (!w_ram_rdata[0]) begin
                    w_ram_we     = 1'b1;
                    w_ram_wdata  = 1'b1;
                    n_res_base   = r_acc;
                    n_res_slot   = r_cnt;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else if (r_cnt == LAST_SLOT) begin
                    n_res_base   = '0;
                    n_res_slot   = '0;
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_cnt = r_cnt + SLOT_W'(1);
                    n_acc = w_alu_rsp.sum;
                end
            end
            S_DIV: begin
                // quotient by repeated subtraction of the region size
                w_alu_req.sub = 1'b1;
                if (!w_alu_rsp.carry) begin
                    w_ram_we     = 1'b1;
                    w_ram_wdata  = 1'b0;
                    n_res_base   = '0;
                    n_res_slot   = r_cnt;
                    n_res_status = ST_OK;
                    n_state      = S_DONE;
                end else if (r_cnt == LAST_SLOT) begin
                    n_res_base   = '0;
                    n_res_slot   = '0;
                    n_res_status = ST_OUTSIDE;
                    n_state      = S_DONE;
                end else begin
                    n_cnt = r_cnt + SLOT_W'(1);
                    n_acc = w_alu_rsp.sum;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_base   = r_res_base;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_pool_base   <= POOL_BASE_RESET;
            r_stack_pages <= PAGES_RESET;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
            r_pool_base   <= n_pool_base;
            r_stack_pages <= n_stack_pages;
        end
        r_acc        <= n_acc;
        r_size       <= n_size;
        r_mode       <= n_mode;
        r_addr       <= n_addr;
        r_res_base   <= n_res_base;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_base   <= n_out_base;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_region_base = r_out_base;
    assign o_slot_index  = SLOTO_W'(r_out_slot);
    assign o_status      = r_out_status;

endmodule

>>> rtl/core/ssba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ssba_addsub.sv
// Shared 48-bit add/subtract unit with carry out.
// Depends on ssba_pkg for widths and the request/response structs.
module ssba_addsub
    import ssba_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ADDR_W:0] w_full;

    // subtract as a + ~b + 1; carry set means no borrow
    assign w_full = {1'b0, i_req.a}
                  + {1'b0, (i_req.sub ? ~i_req.b : i_req.b)}
                  + {{ADDR_W{1'b0}}, i_req.sub};

    assign o_rsp.sum   = w_full[ADDR_W-1:0];
    assign o_rsp.carry = w_full[ADDR_W];

endmodule

>>> tb/stack_slot_bitmap_allocator_top_test.sv
// Self-checking bench for stack_slot_bitmap_allocator_top: a queue-fed driver sends
// allocate/free words, an in-bench slot map predicts each result, a monitor compares them.
// Depends on ssba_pkg and the RTL of the block; needs no files or arguments.
module stack_slot_bitmap_allocator_top_test;
    import ssba_pkg::*;

    localparam int SLOTS       = 64;
    localparam int PAGE_SZ     = 4096;
    // margin to let the longest request, a full scan over every slot, run out
    localparam int SETTLE_CYC  = SLOTS + 16;
    localparam int CHUNK_WORDS = 235;
    localparam int MAX_REPORTS = 10;
    localparam logic MODE_FREE = ~MODE_ALLOC;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    // one request word as the driver presents it; hold makes the driver wait for
    // every outstanding result before presenting it
    typedef struct {
        logic              mode;
        logic [ADDR_W-1:0] addr;
        bit                hold;
    } t_slot_req;

    typedef struct {
        logic [ADDR_W-1:0]  region_base;
        logic [SLOTO_W-1:0] slot_index;
        t_status            status;
    } t_slot_result;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_we        = 1'b0;
    logic               i_cfg_index     = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data      = '0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic               i_mode          = 1'b0;
    logic [ADDR_W-1:0]  i_stack_address = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic [ADDR_W-1:0]  o_region_base;
    logic [SLOTO_W-1:0] o_slot_index;
    logic [1:0]         o_status;

    // bench copy of the block's state and registers
    bit   [SLOTS-1:0]   slot_in_use   = '0;
    logic [ADDR_W-1:0]  cfg_pool_base = POOL_BASE_RESET;
    logic [PAGES_W-1:0] cfg_pages     = PAGES_RESET;

    t_slot_req    req_backlog[$];
    t_slot_result expected_results[$];

    int queued_cnt    = 0;
    int accept_cnt    = 0;
    int result_cnt    = 0;
    int err_cnt       = 0;
    int send_idle_pct = 27;
    int recv_idle_pct = 88;
    logic drained     = 1'b1;

    stack_slot_bitmap_allocator_top #(
        .MAX_SLOTS  (SLOTS),
        .PAGE_BYTES (PAGE_SZ)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_stack_address (i_stack_address),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_region_base   (o_region_base),
        .o_slot_index    (o_slot_index),
        .o_status        (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Region size in bytes; a page count of zero counts as one page.
    function automatic logic [63:0] region_bytes();
        logic [63:0] pages;
        pages = (cfg_pages == '0) ? 64'd1 : 64'(cfg_pages);
        return pages * PAGE_SZ;
    endfunction

    // Address inside slot s at byte offset off, wrapped to the address width.
    function automatic logic [ADDR_W-1:0] slot_addr(int unsigned s, logic [63:0] off);
        logic [63:0] a;
        a = 64'(cfg_pool_base) + 64'(s) * region_bytes() + off;
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ADDR_W-1:0];
    endfunction

    // Applies one accepted word to the bench slot map and returns the result
    // the block must produce for it.
    function automatic t_slot_result predict_slot_result(logic mode, logic [ADDR_W-1:0] addr);
        t_slot_result r;
        logic [63:0]  size;
        logic [63:0]  slot;
        logic [63:0]  base;
        bit           found;
        r.region_base = '0;
        r.slot_index  = '0;
        r.status      = ST_OK;
        size  = region_bytes();
        slot  = '0;
        found = 1'b0;
        if (mode == MODE_ALLOC) begin
            // walk down so the last hit is the lowest free slot
            for (int k = SLOTS - 1; k >= 0; k--) begin
                if (!slot_in_use[k]) begin
                    found = 1'b1;
                    slot  = 64'(k);
                end
            end
            if (found) begin
                slot_in_use[slot] = 1'b1;
                base          = 64'(cfg_pool_base) + slot * size;
                r.region_base = base[ADDR_W-1:0];
                r.slot_index  = slot[SLOTO_W-1:0];
            end else begin
                r.status = ST_FULL;
            end
        end else if (addr < cfg_pool_base) begin
            r.status = ST_OUTSIDE;
        end else begin
            // any address inside a region frees the slot that holds it
            slot = (64'(addr) - 64'(cfg_pool_base)) / size;
            if (slot >= SLOTS) begin
                r.status = ST_OUTSIDE;
            end else begin
                slot_in_use[slot] = 1'b0;
                r.slot_index      = slot[SLOTO_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void push_req(logic mode, logic [ADDR_W-1:0] addr, bit hold);
        t_slot_req w;
        w.mode = mode;
        w.addr = addr;
        w.hold = hold;
        req_backlog.push_back(w);
        queued_cnt++;
    endfunction

    // One random word. Most frees land in the pool, aligned or not; the rest
    // go below the base, past the last slot, or anywhere at all.
    function automatic void push_random_word(int p_alloc, bit hold);
        int unsigned roll;
        logic [63:0] off;
        logic [ADDR_W-1:0] a;
        roll = $urandom_range(99);
        off  = $urandom_range(1) ? 64'd0 : 64'($urandom) % region_bytes();
        if (roll < p_alloc) begin
            push_req(MODE_ALLOC, rand_addr(), hold);
        end else if (roll < p_alloc + (100 - p_alloc) * 7 / 10) begin
            push_req(MODE_FREE, slot_addr($urandom_range(SLOTS - 1), off), hold);
        end else begin
            case ($urandom_range(2))
                0: a = (cfg_pool_base != '0) ? rand_addr() % cfg_pool_base : rand_addr();
                1: a = slot_addr($urandom_range(SLOTS, SLOTS + 20), off);
                default: a = rand_addr();
            endcase
            push_req(MODE_FREE, a, hold);
        end
    endfunction

    // Wait until every queued word is accepted and answered, then let the
    // block run out its longest request.
    task automatic settle();
        do @(negedge i_clk);
        while (accept_cnt != queued_cnt || result_cnt != accept_cnt);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_POOL_BASE) begin
            cfg_pool_base = val[ADDR_W-1:0];
        end else begin
            cfg_pages = val[PAGES_W-1:0];
        end
    endtask

    task automatic run_chunk(int s_idle, int r_idle, logic [ADDR_W-1:0] base,
                             logic [PAGES_W-1:0] pages);
        int p_alloc;
        settle();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_STACK_PAGES, pages);
        @(negedge i_clk);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < CHUNK_WORDS; n++) begin
            // allocate-heavy first so the pool fills, then mostly frees
            case (n / 80)
                0:       p_alloc = 90;
                1:       p_alloc = 40;
                default: p_alloc = 20;
            endcase
            push_random_word(p_alloc, n == 120);
        end
    endtask

    // Sampled at the falling edge so the driver sees a settled value.
    always @(negedge i_clk) begin
        drained <= (accept_cnt == result_cnt);
    end

    // Driver: a word is accepted at an edge where valid is high and stall low;
    // a stalled word is held unchanged, otherwise the next one may follow.
    always @(posedge i_clk) begin : drive_words
        bit        took;
        t_slot_req nxt;
        took = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (took) begin
                expected_results.push_back(predict_slot_result(i_mode, i_stack_address));
                accept_cnt++;
            end
            if (!i_valid || took) begin
                if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct
                        && (!req_backlog[0].hold || (drained && !took))) begin
                    nxt = req_backlog.pop_front();
                    i_valid         <= 1'b1;
                    i_mode          <= nxt.mode;
                    i_stack_address <= nxt.addr;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : check_words
        t_slot_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                result_cnt++;
                if (expected_results.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS) begin
                        $display("unexpected result: base=%h slot=%0d status=%0d",
                                 o_region_base, o_slot_index, o_status);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (o_region_base !== want.region_base || o_slot_index !== want.slot_index
                            || o_status !== want.status) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS) begin
                            $display("mismatch base/slot/status: exp %h %0d %0d, got %h %0d %0d",
                                     want.region_base, want.slot_index, want.status,
                                     o_region_base, o_slot_index, o_status);
                        end
                    end
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin : run_phases
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at reset register values (2 TiB base, 1 MiB regions).
        // The block stalls input during its clearing pass; the driver just waits.
        @(negedge i_clk);
        push_req(MODE_ALLOC, '0, 1'b0);
        push_req(MODE_ALLOC, ADDR_MAX, 1'b0);             // address ignored on allocate
        push_req(MODE_ALLOC, '0, 1'b0);
        push_req(MODE_FREE, slot_addr(1, 0), 1'b0);
        push_req(MODE_ALLOC, '0, 1'b0);                   // reuses the hole at slot 1
        push_req(MODE_FREE, slot_addr(2, region_bytes() - 1), 1'b0);  // last byte of slot 2
        push_req(MODE_FREE, slot_addr(2, 0), 1'b0);       // slot already free
        push_req(MODE_FREE, '0, 1'b0);                    // below the pool base
        push_req(MODE_FREE, slot_addr(SLOTS, 0), 1'b0);   // just past the last slot
        push_req(MODE_FREE, ADDR_MAX, 1'b0);
        push_req(MODE_FREE, slot_addr(SLOTS - 1, region_bytes() - 1), 1'b0);
        settle();

        // Base at the top of the address space with regions of 65536 pages: every
        // slot above zero wraps, and freeing a wrapped base falls below the pool.
        write_reg(CFG_POOL_BASE, ADDR_MAX);
        write_reg(CFG_STACK_PAGES, 65536);
        @(negedge i_clk);
        push_req(MODE_ALLOC, '0, 1'b0);
        push_req(MODE_FREE, ADDR_MAX, 1'b0);
        push_req(MODE_FREE, slot_addr(2, 0), 1'b0);
        push_req(MODE_ALLOC, '0, 1'b0);
        settle();

        // Base zero and a page count of zero, which acts as one page.
        write_reg(CFG_POOL_BASE, '0);
        write_reg(CFG_STACK_PAGES, '0);
        @(negedge i_clk);
        push_req(MODE_FREE, '0, 1'b0);
        push_req(MODE_ALLOC, '0, 1'b0);
        push_req(MODE_FREE, slot_addr(SLOTS, 0), 1'b0);
        push_req(MODE_FREE, slot_addr(SLOTS - 1, region_bytes() - 1), 1'b0);
        push_req(MODE_ALLOC, '0, 1'b0);

        // Random part: sender idles lightly and sink heavily, then the reverse,
        // then neither side idles.
        run_chunk(27, 88, '0, 1);
        run_chunk(27, 88, POOL_BASE_RESET, 65536);
        run_chunk(88, 27, rand_addr(), PAGES_W'($urandom_range(1, 65536)));
        run_chunk(88, 27, 48'hFFFF_FF00_0000, 4096);
        run_chunk(0, 0, ADDR_MAX, PAGES_RESET);
        run_chunk(0, 0, POOL_BASE_RESET, PAGES_RESET);
        settle();

        if (expected_results.size() != 0) begin
            err_cnt++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin : watchdog
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
